[rtl/sfbf_pkg.sv]
// ----------------------------------------------------------------------------
// Symmetric FIR band-stop filter package
// Shared widths, defaults, control structs and the half-filter coefficient ROM.
// ----------------------------------------------------------------------------
package sfbf_pkg;

  localparam int TAPS_DEF           = 201;
  localparam int SAMPLE_BITS_DEF    = 12;
  localparam int COEF_FRAC_BITS_DEF = 17;

  localparam int COEF_W     = 18;
  localparam int OUT_W      = 16;
  localparam int DIST_W     = 8;
  localparam int ROM_CENTER = 100;
  localparam int ROM_IDX_W  = 7;
  localparam int GUARD_W    = 8;

  typedef struct packed {
    logic start;
    logic step;
    logic load_out;
  } sfbf_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic busy;
    logic out_full;
  } sfbf_stat_t;

  localparam logic signed [COEF_W-1:0] COEF_ROM [0:ROM_CENTER] = '{
    18'sd67, 18'sd64, 18'sd55, 18'sd41, 18'sd22, 18'sd0,
    -18'sd23, -18'sd45, -18'sd64, -18'sd78,
    -18'sd85, -18'sd83, -18'sd73, -18'sd54, -18'sd29, 18'sd0,
    18'sd31, 18'sd59, 18'sd83, 18'sd98,
    18'sd103, 18'sd97, 18'sd82, 18'sd58, 18'sd30, 18'sd0,
    -18'sd27, -18'sd47, -18'sd58, -18'sd58,
    -18'sd50, -18'sd36, -18'sd18, -18'sd4, 18'sd4, 18'sd0,
    -18'sd17, -18'sd48, -18'sd88, -18'sd132,
    -18'sd171, -18'sd196, -18'sd197, -18'sd166, -18'sd101, 18'sd0,
    18'sd129, 18'sd276, 18'sd423, 18'sd550,
    18'sd637, 18'sd664, 18'sd616, 18'sd487, 18'sd277, 18'sd0,
    -18'sd321, -18'sd656, -18'sd965, -18'sd1210,
    -18'sd1353, -18'sd1365, -18'sd1229, -18'sd943, -18'sd523, 18'sd0,
    18'sd577, 18'sd1150, 18'sd1655, 18'sd2031,
    18'sd2225, 18'sd2202, 18'sd1945, 18'sd1465, 18'sd797, 18'sd0,
    -18'sd851, -18'sd1667, -18'sd2361, -18'sd2852,
    -18'sd3078, -18'sd2999, -18'sd2611, -18'sd1938, -18'sd1040, 18'sd0,
    18'sd1079, 18'sd2086, 18'sd2916, 18'sd3476,
    18'sd3701, 18'sd3561, 18'sd3060, 18'sd2243, 18'sd1189, 18'sd0,
    -18'sd1203, -18'sd2298, -18'sd3172, -18'sd3736,
    18'sd127086
  };

  function automatic logic signed [COEF_W-1:0] tap_coef(input logic [DIST_W-1:0] tap_dist);
    logic [DIST_W-1:0] idx;
    idx = DIST_W'(ROM_CENTER) - tap_dist;
    if (tap_dist > DIST_W'(ROM_CENTER)) begin
      return '0;
    end
    return COEF_ROM[idx[ROM_IDX_W-1:0]];
  endfunction

endpackage

[rtl/sfbf_ctrl.sv]
// ----------------------------------------------------------------------------
// Symmetric FIR band-stop filter controller
// Sequences one item: sample write, one tap per cycle, pipeline drain, output load.
// ----------------------------------------------------------------------------
module sfbf_ctrl
  import sfbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  sfbf_stat_t stat,
  output sfbf_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.start    = 1'b0;
    cmd.step     = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        if (in_valid) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (stat.last_tap) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.busy && !stat.out_full) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == S_RUN)
    else $error("start did not enter run");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !stat.out_full && !stat.busy)
    else $error("output loaded while full or busy");
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    cmd.step && stat.last_tap |=> state == S_DRAIN && !cmd.step)
    else $error("tap walk did not stop at last tap");
`endif

endmodule

[rtl/sfbf_dp.sv]
// ----------------------------------------------------------------------------
// Symmetric FIR band-stop filter datapath
// Sample store, coefficient lookup, shared multiply-accumulate and output register.
// ----------------------------------------------------------------------------
module sfbf_dp
  import sfbf_pkg::*;
#(
  parameter int TAPS           = TAPS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sfbf_cmd_t              cmd,
  output sfbf_stat_t             stat,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [OUT_W-1:0]       filtered,
  output logic                   out_valid,
  input  logic                   out_ready
);

  localparam int PTR_W  = $clog2(TAPS);
  localparam int HALF   = (TAPS - 1) / 2;
  localparam int PROD_W = SAMPLE_BITS + 1 + COEF_W;
  localparam int ACC_W  = PROD_W + GUARD_W;

  logic [SAMPLE_BITS-1:0] mem [TAPS];
  logic [TAPS-1:0]        filled;

  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] rd_addr_inc;
  logic [PTR_W-1:0] k;

  logic [DIST_W-1:0] k_ext;
  logic [DIST_W-1:0] mir;
  logic [DIST_W-1:0] d1;
  logic [DIST_W-1:0] d2;
  logic [DIST_W-1:0] tap_dist;

  logic                     v1;
  logic                     v2;
  logic [SAMPLE_BITS-1:0]   rd_data;
  logic                     rd_filled;
  logic signed [COEF_W-1:0] coef_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]         sh;
  logic [OUT_W-1:0]         clamped;

  assign wp_inc      = (wp == PTR_W'(TAPS - 1)) ? '0 : wp + 1'b1;
  assign rd_addr_inc = (rd_addr == PTR_W'(TAPS - 1)) ? '0 : rd_addr + 1'b1;

  assign k_ext    = DIST_W'(k);
  assign mir      = DIST_W'(TAPS - 1) - k_ext;
  assign d1       = (k_ext >= DIST_W'(HALF)) ? k_ext - DIST_W'(HALF) : DIST_W'(HALF) - k_ext;
  assign d2       = (mir >= DIST_W'(HALF)) ? mir - DIST_W'(HALF) : DIST_W'(HALF) - mir;
  assign tap_dist = (d2 < d1) ? d2 : d1;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mem[wp] <= sample;
    end
    if (cmd.step) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      wp     <= '0;
      v1     <= 1'b0;
      v2     <= 1'b0;
    end else begin
      if (cmd.start) begin
        filled[wp] <= 1'b1;
        wp         <= wp_inc;
      end
      v1 <= cmd.step;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_addr <= wp_inc;
      k       <= '0;
      acc     <= '0;
    end else begin
      if (cmd.step) begin
        rd_addr <= rd_addr_inc;
        k       <= k + 1'b1;
      end
      if (v2) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (cmd.step) begin
      rd_filled <= filled[rd_addr];
      coef_q    <= tap_coef(tap_dist);
    end
    if (v1) begin
      prod <= coef_q * $signed({1'b0, (rd_filled ? rd_data : {SAMPLE_BITS{1'b0}})});
    end
  end

  assign sh      = ACC_W'(unsigned'(acc)) >> COEF_FRAC_BITS;
  assign clamped = acc[ACC_W-1] ? '0 :
                   (|sh[ACC_W-1:OUT_W]) ? {OUT_W{1'b1}} : sh[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      filtered <= clamped;
    end
  end

  assign stat.last_tap = (k == PTR_W'(TAPS - 1));
  assign stat.busy     = v1 | v2;
  assign stat.out_full = out_valid & ~out_ready;

`ifndef SYNTHESIS
  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    wp <= PTR_W'(TAPS - 1))
    else $error("write pointer out of range");
  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> v1 ##1 v2)
    else $error("tap pipeline lost a step");
`endif

endmodule

[rtl/symmetric_fir_bandstop_filter.sv]
// ----------------------------------------------------------------------------
// Symmetric FIR band-stop filter, top level
// Accepts a new input item only after the previous result has been loaded
//   into the output register; the single multiply-accumulate unit walks
//   one tap per cycle.
// A finished result waits in the output register while the next item runs.
// Reset: synchronous, clears the controller, write pointer, store fill bits
//   (store reads as zero) and the output valid.
// ----------------------------------------------------------------------------
module symmetric_fir_bandstop_filter
  import sfbf_pkg::*;
#(
  parameter int TAPS           = TAPS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_BITS + 7) / 8)*8-1:0] s_tdata,   // [SAMPLE_BITS-1:0] sample
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [OUT_W-1:0]                     m_tdata    // [15:0] filtered
);

  sfbf_cmd_t  cmd;
  sfbf_stat_t stat;

  sfbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfbf_dp #(
    .TAPS           (TAPS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .sample    (s_tdata[SAMPLE_BITS-1:0]),
    .filtered  (m_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

endmodule

[dv/symmetric_fir_bandstop_filter_chk.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Band-stop filter checker
// Watches both item channels. Keeps its own sample history and notch
// coefficients, predicts each filtered value when a sample is accepted, and
// compares every output item against the oldest prediction.
// ----------------------------------------------------------------------------
module symmetric_fir_bandstop_filter_chk
  import sfbf_pkg::*;
#(
  parameter int TAPS           = TAPS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  input  logic                                 s_tready,
  input  logic [((SAMPLE_BITS + 7) / 8)*8-1:0] s_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic [OUT_W-1:0]                     m_tdata,   // [15:0] filtered
  output int                                   errors,
  output int                                   pending,
  output int                                   samples_in,
  output int                                   values_out,
  output int                                   zero_values
);

  localparam int FILTERED_MAX = (1 << OUT_W) - 1;

  // Q1.17 half filter, outermost tap first, centre tap last
  localparam int NOTCH_HALF [0:ROM_CENTER] = '{
    67, 64, 55, 41, 22, 0, -23, -45, -64, -78,
    -85, -83, -73, -54, -29, 0, 31, 59, 83, 98,
    103, 97, 82, 58, 30, 0, -27, -47, -58, -58,
    -50, -36, -18, -4, 4, 0, -17, -48, -88, -132,
    -171, -196, -197, -166, -101, 0, 129, 276, 423, 550,
    637, 664, 616, 487, 277, 0, -321, -656, -965, -1210,
    -1353, -1365, -1229, -943, -523, 0, 577, 1150, 1655, 2031,
    2225, 2202, 1945, 1465, 797, 0, -851, -1667, -2361, -2852,
    -3078, -2999, -2611, -1938, -1040, 0, 1079, 2086, 2916, 3476,
    3701, 3561, 3060, 2243, 1189, 0, -1203, -2298, -3172, -3736,
    127086
  };

  logic [SAMPLE_BITS-1:0] history [TAPS];
  int                     wr_ptr;
  logic [OUT_W-1:0]       expected_filtered [$];

  function automatic int notch_coef(input int k);
    int tap_dist;
    int mirror_dist;
    tap_dist = k - (TAPS - 1) / 2;
    if (tap_dist < 0) tap_dist = -tap_dist;
    mirror_dist = (TAPS - 1 - k) - (TAPS - 1) / 2;
    if (mirror_dist < 0) mirror_dist = -mirror_dist;
    if (mirror_dist < tap_dist) tap_dist = mirror_dist;
    if (tap_dist > ROM_CENTER) return 0;
    return NOTCH_HALF[ROM_CENTER - tap_dist];
  endfunction

  // store the sample, advance, then sum oldest to newest
  function automatic logic [OUT_W-1:0] filter_sample(input logic [SAMPLE_BITS-1:0] sample);
    longint acc;
    int     idx;
    acc = 0;
    history[wr_ptr] = sample;
    wr_ptr = (wr_ptr + 1) % TAPS;
    for (int k = 0; k < TAPS; k++) begin
      idx = (wr_ptr + k) % TAPS;
      acc += longint'(notch_coef(k)) * longint'(history[idx]);
    end
    if (acc < 0) return '0;
    acc = acc >>> COEF_FRAC_BITS;
    if (acc > FILTERED_MAX) return OUT_W'(FILTERED_MAX);
    return OUT_W'(acc);
  endfunction

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst) begin
      for (int i = 0; i < TAPS; i++) history[i] = '0;
      wr_ptr = 0;
      expected_filtered.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        want = filter_sample(s_tdata[SAMPLE_BITS-1:0]);
        expected_filtered.push_back(want);
        samples_in++;
        if (want == '0) zero_values++;
      end
      if (m_tvalid && m_tready) begin
        values_out++;
        if (expected_filtered.size() == 0) begin
          errors++;
          $error("filtered: expected none, actual %0d", m_tdata);
        end else begin
          want = expected_filtered.pop_front();
          if (m_tdata !== want) begin
            errors++;
            $error("filtered: expected %0d, actual %0d", want, m_tdata);
          end
        end
      end
    end
    pending = expected_filtered.size();
  end

endmodule

[dv/symmetric_fir_bandstop_filter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Band-stop filter testbench
// Feeds ADC samples into the filter: a short impulse and extreme-value run,
// then random segments of noise, extremes, square waves, impulse trains and
// steps, with random idling on both channels. The checker judges each output.
// ----------------------------------------------------------------------------
module symmetric_fir_bandstop_filter_tb;
  import sfbf_pkg::*;

  localparam int DATA_W        = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS_DEF) - 1;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = TAPS_DEF + 20;
  localparam int QUIET_FIRST   = 800;
  localparam int QUIET_LAST    = 1100;

  typedef enum int {
    PAT_UNIFORM,
    PAT_EXTREME,
    PAT_SQUARE,
    PAT_IMPULSE,
    PAT_STEP
  } pattern_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  bit                quiet    = 1'b0;
  int                stall_cycles = 0;
  int                errors;
  int                pending;
  int                samples_in;
  int                values_out;
  int                zero_values;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  symmetric_fir_bandstop_filter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  symmetric_fir_bandstop_filter_chk u_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .pending     (pending),
    .samples_in  (samples_in),
    .values_out  (values_out),
    .zero_values (zero_values)
  );

  always @(negedge clk) begin
    m_tready <= !rst && (quiet || $urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("no item moved for %0d cycles", STALL_LIMIT);
    $display("symmetric_fir_bandstop_filter_tb: errors");
    $finish;
  end

  // hold the item until accepted, return at the next falling edge
  task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] sample);
    while (!quiet && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= DATA_W'(sample);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [SAMPLE_BITS_DEF-1:0] directed [$];
    logic [SAMPLE_BITS_DEF-1:0] value;
    pattern_t                   pattern;
    int                         run_len;
    int                         half_period;
    int                         sent;

    // impulse first so its tail walks the negative taps
    directed = '{12'hFFF, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
                 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
                 12'h000, 12'h555, 12'hAAA, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                 12'h000, 12'h001, 12'h800};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) send_sample(directed[i]);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pattern     = pattern_t'($urandom_range(PAT_STEP));
      run_len     = $urandom_range(10, 80);
      half_period = $urandom_range(1, 25);
      quiet       = (sent >= QUIET_FIRST && sent < QUIET_LAST);
      for (int i = 0; i < run_len; i++) begin
        case (pattern)
          PAT_UNIFORM: begin
            value = SAMPLE_BITS_DEF'($urandom_range(SAMPLE_MAX));
          end
          PAT_EXTREME: begin
            case ($urandom_range(2))
              0: value = '0;
              1: value = SAMPLE_BITS_DEF'(SAMPLE_MAX);
              default: value = SAMPLE_BITS_DEF'(1 << $urandom_range(SAMPLE_BITS_DEF - 1));
            endcase
          end
          PAT_SQUARE: begin
            value = ((i / half_period) % 2) ? '0 : SAMPLE_BITS_DEF'(SAMPLE_MAX);
          end
          PAT_IMPULSE: begin
            value = (i % (half_period * 4) == 0) ? SAMPLE_BITS_DEF'(SAMPLE_MAX) : '0;
          end
          default: begin
            value = (i < run_len / 2) ? SAMPLE_BITS_DEF'(SAMPLE_MAX - $urandom_range(63))
                                      : SAMPLE_BITS_DEF'($urandom_range(63));
          end
        endcase
        send_sample(value);
      end
      sent += run_len;
    end
    quiet    = 1'b0;
    s_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d samples fed (impulse, extremes, noise, square, step runs),",
             samples_in);
    $display("%0d filtered values compared, %0d of them zero", values_out, zero_values);
    if (errors == 0) begin
      $display("symmetric_fir_bandstop_filter_tb: clean");
    end else begin
      $display("symmetric_fir_bandstop_filter_tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sfbf_pkg.sv
rtl/sfbf_ctrl.sv
rtl/sfbf_dp.sv
rtl/symmetric_fir_bandstop_filter.sv
dv/symmetric_fir_bandstop_filter_chk.sv
dv/symmetric_fir_bandstop_filter_tb.sv
